FILE: sv/attb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attb_pkg
// Shared constants, codes and types of the activation TTL timer bank.
// ----------------------------------------------------------------------------
package attb_pkg;

    // Table geometry
    localparam int OWNERS  = 6;
    localparam int SLOTS   = 8;
    localparam int N_CELLS = OWNERS * SLOTS;
    localparam int OWN_W   = (OWNERS > 1) ? $clog2(OWNERS) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Command codes
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Result codes
    localparam logic [1:0] RES_ADD     = 2'd0;
    localparam logic [1:0] RES_REMOVE  = 2'd1;
    localparam logic [1:0] RES_REFRESH = 2'd2;
    localparam logic [1:0] RES_DONE    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WORLD_COUNT = 1'b0;
    localparam logic CFG_ACT_TTL     = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } t_state;

    // Ring control from the controller to the cell row
    typedef struct packed {
        logic shift;
        logic clear;
    } t_ring_ctl;

endpackage

FILE: sv/attb_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attb_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface attb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  owner;
    logic [2:0]  slot;
    logic [31:0] elapsed_ms;

    modport source (output valid, output cmd, output owner, output slot,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input cmd, input owner, input slot,
                    input elapsed_ms, output ready);
endinterface
`default_nettype wire

FILE: sv/attb_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attb_out_if
// Event channel: valid/ready handshake with one event result.
// ----------------------------------------------------------------------------
interface attb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [2:0] event_owner;
    logic [2:0] event_slot;
    logic       last;

    modport source (output valid, output event_res, output event_owner,
                    output event_slot, output last, input ready);
    modport sink   (input valid, input event_res, input event_owner,
                    input event_slot, input last, output ready);
endinterface
`default_nettype wire

FILE: sv/attb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attb_cell
// One timer of the ring: holds 8 bits, takes its neighbor's value on shift.
// ----------------------------------------------------------------------------
module attb_cell (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire attb_pkg::t_ring_ctl  i_ctl,
    input  wire  [7:0]                i_d,
    output logic [7:0]                o_q
);
    import attb_pkg::*;

    logic [7:0] r_ttl;

    // Timer storage; clear wins over shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= 8'd0;
        end else if (i_ctl.clear) begin
            r_ttl <= 8'd0;
        end else if (i_ctl.shift) begin
            r_ttl <= i_d;
        end
    end

    assign o_q = r_ttl;

endmodule
`default_nettype wire

FILE: sv/attb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attb_ctrl
// Command sequencer: walks the ring once per tick or valid activate, updates the
// timer at the ring head and queues events into the output register.
// ----------------------------------------------------------------------------
module attb_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    attb_in_if.sink              i_in,
    attb_out_if.source           o_out,
    input  wire  [3:0]           i_world_count,
    input  wire  [7:0]           i_act_ttl,
    input  wire  [7:0]           i_head,
    output logic [7:0]           o_feed,
    output attb_pkg::t_ring_ctl  o_ring
);
    import attb_pkg::*;

    t_state              r_state, n_state;
    logic [OWN_W-1:0]    r_owner;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_is_tick;
    logic [31:0]         r_elapsed;
    logic [2:0]          r_act_owner;
    logic [2:0]          r_act_slot;

    logic                r_out_valid;
    logic [1:0]          r_out_res;
    logic [2:0]          r_out_owner;
    logic [2:0]          r_out_slot;
    logic                r_out_last;

    logic [3:0]          w_used;
    logic                w_accept;
    logic                w_act_ok;
    logic                w_in_use;
    logic                w_expire;
    logic                w_match;
    logic                w_emit;
    logic                w_out_free;
    logic                w_step;
    logic                w_last_pos;
    logic                w_load;
    logic [1:0]          w_load_res;
    logic                w_load_last;
    logic                w_load_pos;

    // Slots in use, limited to the table width
    assign w_used = (i_world_count > 4'(SLOTS)) ? 4'(SLOTS) : i_world_count;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_act_ok   = (i_in.owner < 3'(OWNERS)) && (4'(i_in.slot) < w_used);
    assign w_out_free = !r_out_valid || o_out.ready;

    // Head-of-ring evaluation
    assign w_in_use = 4'(r_slot) < w_used;
    assign w_expire = r_is_tick && w_in_use && (i_head != 8'd0) &&
                      ((r_elapsed[31:8] != 24'd0) || (r_elapsed[7:0] >= i_head));
    assign w_match  = !r_is_tick && (3'(r_owner) == r_act_owner) &&
                      (4'(r_slot) == 4'(r_act_slot));
    assign w_last_pos = (r_owner == OWN_W'(OWNERS - 1)) &&
                        (r_slot == SLOT_W'(SLOTS - 1));

    always_comb begin
        o_feed = i_head;
        if (r_is_tick) begin
            if (w_expire) begin
                o_feed = 8'd0;
            end else if (w_in_use && (i_head != 8'd0)) begin
                o_feed = i_head - r_elapsed[7:0];
            end
        end else if (w_match) begin
            o_feed = i_act_ttl;
        end
    end

    assign w_emit = (r_state == ST_WALK) && (w_expire || w_match);
    assign w_step = !w_emit || w_out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((i_in.cmd == CMD_TICK) ||
                        ((i_in.cmd == CMD_ACTIVATE) && w_act_ok)) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (w_step && w_last_pos) begin
                    n_state = r_is_tick ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_in.ready   = 1'b0;
        o_ring.shift = 1'b0;
        o_ring.clear = 1'b0;
        w_load       = 1'b0;
        w_load_res   = RES_DONE;
        w_load_last  = 1'b1;
        w_load_pos   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // ready is always high here, so valid alone marks a transfer
                i_in.ready   = 1'b1;
                o_ring.clear = i_in.valid && (i_in.cmd == CMD_CLEAR);
            end
            ST_WALK: begin
                o_ring.shift = w_step;
                w_load       = w_emit && w_out_free;
                w_load_pos   = 1'b1;
                if (w_expire) begin
                    w_load_res  = RES_REMOVE;
                    w_load_last = 1'b0;
                end else begin
                    w_load_res  = (i_head == 8'd0) ? RES_ADD : RES_REFRESH;
                    w_load_last = 1'b1;
                end
            end
            ST_DONE: begin
                w_load = w_out_free;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_owner <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_owner <= '0;
                r_slot  <= '0;
            end else if ((r_state == ST_WALK) && w_step) begin
                if (r_slot == SLOT_W'(SLOTS - 1)) begin
                    r_slot  <= '0;
                    r_owner <= r_owner + OWN_W'(1);
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_tick   <= (i_in.cmd == CMD_TICK);
            r_elapsed   <= i_in.elapsed_ms;
            r_act_owner <= i_in.owner;
            r_act_slot  <= i_in.slot;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_res   <= w_load_res;
            r_out_last  <= w_load_last;
            r_out_owner <= w_load_pos ? 3'(r_owner) : 3'd0;
            r_out_slot  <= w_load_pos ? 3'(r_slot) : 3'd0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_out_res;
    assign o_out.event_owner = r_out_owner;
    assign o_out.event_slot  = r_out_slot;
    assign o_out.last        = r_out_last;

endmodule
`default_nettype wire

FILE: sv/activation_ttl_timer_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// activation_ttl_timer_bank
// Bank of 8-bit countdown timers, one per owner and slot, held in a ring of
// cells that rotates past a single update unit.
//
// Commands arrive on i_in (tick, activate, clear); events leave on o_out,
// one or more per command, the final one flagged by last.
// A tick or a valid activate rotates the full ring of 48 cells once, one
// cell per cycle unless o_out stalls, through the update unit at the ring
// head. An activate presents its event as the addressed entry passes the
// head. A tick, a clear and an ignored command each end with a done
// event. No new command is taken until the current one has loaded its
// last event and any walk has ended. Removes of a tick come out in
// owner-major, then slot, order, followed by a done event. A valid
// activate gives one add or refresh event. When o_out stalls with an
// event pending, the ring holds its position until the event is
// transferred.
// Reset zeroes all timers, sets world_count to 0 and activation_ttl to 255.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data; the user
// must do so only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module activation_ttl_timer_bank (
    input  wire        i_clk,
    input  wire        i_rst_n,
    attb_in_if.sink    i_in,
    attb_out_if.source o_out,
    input  wire        i_cfg_we,
    input  wire        i_cfg_idx,
    input  wire  [7:0] i_cfg_data
);
    import attb_pkg::*;

    logic [3:0]  r_world_count;
    logic [7:0]  r_act_ttl;
    logic [7:0]  w_q [N_CELLS];
    logic [7:0]  w_feed;
    t_ring_ctl   w_ring;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_world_count <= 4'd0;
            r_act_ttl     <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WORLD_COUNT: r_world_count <= i_cfg_data[3:0];
                CFG_ACT_TTL:     r_act_ttl     <= i_cfg_data;
                default:         r_act_ttl     <= r_act_ttl;
            endcase
        end
    end

    // Ring of timer cells; entry i sits in cell N_CELLS-1-i at rest
    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_head
            attb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ring),
                .i_d     (w_feed),
                .o_q     (w_q[k])
            );
        end else begin : g_body
            attb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ring),
                .i_d     (w_q[k-1]),
                .o_q     (w_q[k])
            );
        end
    end

    // Sequencer and update unit
    attb_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_world_count (r_world_count),
        .i_act_ttl     (r_act_ttl),
        .i_head        (w_q[N_CELLS-1]),
        .o_feed        (w_feed),
        .o_ring        (w_ring)
    );

endmodule
`default_nettype wire

FILE: sv/attb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// attb_checker
// Port-level checks of the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module attb_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [1:0] i_out_res,
    input wire [2:0] i_out_owner,
    input wire [2:0] i_out_slot,
    input wire       i_out_last
);
    import attb_pkg::*;

    // A stalled event holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_res) &&
        $stable(i_out_owner) && $stable(i_out_slot) && $stable(i_out_last))
        else $error("event changed while stalled");

    // One command in work at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command taken while busy");

    // Done events carry no position
    a_done_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_res == RES_DONE) |->
        (i_out_owner == 3'd0) && (i_out_slot == 3'd0))
        else $error("done event with position");

    // Only removes are followed by more events of the same command
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_res != RES_REMOVE)))
        else $error("last flag mismatch");

endmodule

bind activation_ttl_timer_bank attb_checker u_attb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_res   (o_out.event_res),
    .i_out_owner (o_out.event_owner),
    .i_out_slot  (o_out.event_slot),
    .i_out_last  (o_out.last)
);
`default_nettype wire
